// ===== hw/rtl/ptp_pkg.sv =====
`timescale 1ns / 1ps
package ptp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int MAG_W = 33;
   localparam int ANG_W = 17;

   localparam logic [18:0] ATAN_TAB [CORDIC_STEPS] = '{
      19'd51472, 19'd30385, 19'd16055, 19'd8150, 19'd4091, 19'd2047, 19'd1024, 19'd512,
      19'd256, 19'd128, 19'd64, 19'd32, 19'd16, 19'd8, 19'd4, 19'd2
   };

   typedef enum logic [2:0] {
      REG_PAN_MIN    = 3'd0,
      REG_PAN_MAX    = 3'd1,
      REG_TILT_MIN   = 3'd2,
      REG_TILT_MAX   = 3'd3,
      REG_CAL_DEPTH  = 3'd4,
      REG_CAL_WIDTH  = 3'd5,
      REG_CAL_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [18:0] z;
      logic               zero;
   } cordic_lane_type;

   // lanes: pan angle, pan full view, tilt angle, tilt full view
   typedef struct packed {
      logic                  valid;
      logic [1:0]            low;
      cordic_lane_type [3:0] lane;
   } cordic_word_type;

   typedef struct packed {
      logic [ANG_W-1:0] rem;
      logic [MAG_W-1:0] num;
      logic [ANG_W-1:0] full;
      logic             neg;
      logic             fz;
   } div_lane_type;

   typedef struct packed {
      logic               valid;
      div_lane_type [1:0] lane;
   } div_word_type;

endpackage

// ===== hw/rtl/ptp_if.sv =====
`timescale 1ns / 1ps
interface ptp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ptp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pan_pulse;
   logic [15:0] tilt_pulse;
   modport source (output valid, output pan_pulse, output tilt_pulse, input ready);
   modport sink (input valid, input pan_pulse, input tilt_pulse, output ready);
endinterface

// ===== hw/rtl/ptp_cordic_cell.sv =====
`timescale 1ns / 1ps
module ptp_cordic_cell
   import ptp_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  cordic_word_type word_in,
   output cordic_word_type word_out
);

   cordic_word_type word_ff;
   cordic_word_type word_in_c;

   always_comb begin
      word_in_c = word_in;
      for (int k = 0; k < 4; k++) begin
         if (!word_in.lane[k].y[31] && (word_in.lane[k].y != 32'sd0)) begin
            word_in_c.lane[k].x = word_in.lane[k].x + (word_in.lane[k].y >>> STEP);
            word_in_c.lane[k].y = word_in.lane[k].y - (word_in.lane[k].x >>> STEP);
            word_in_c.lane[k].z = word_in.lane[k].z + $signed(ATAN_TAB[STEP]);
         end else begin
            word_in_c.lane[k].x = word_in.lane[k].x - (word_in.lane[k].y >>> STEP);
            word_in_c.lane[k].y = word_in.lane[k].y + (word_in.lane[k].x >>> STEP);
            word_in_c.lane[k].z = word_in.lane[k].z - $signed(ATAN_TAB[STEP]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (adv) begin
         word_ff <= word_in_c;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== hw/rtl/ptp_div_cell.sv =====
`timescale 1ns / 1ps
module ptp_div_cell
   import ptp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  div_word_type word_in,
   output div_word_type word_out
);

   div_word_type word_ff;
   div_word_type word_in_c;
   logic [ANG_W:0] trial [2];

   always_comb begin
      word_in_c = word_in;
      for (int k = 0; k < 2; k++) begin
         trial[k] = {word_in.lane[k].rem, word_in.lane[k].num[MAG_W-1]};
         if (trial[k] >= {1'b0, word_in.lane[k].full}) begin
            word_in_c.lane[k].rem = ANG_W'(trial[k] - {1'b0, word_in.lane[k].full});
            word_in_c.lane[k].num = {word_in.lane[k].num[MAG_W-2:0], 1'b1};
         end else begin
            word_in_c.lane[k].rem = trial[k][ANG_W-1:0];
            word_in_c.lane[k].num = {word_in.lane[k].num[MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (adv) begin
         word_ff <= word_in_c;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== hw/rtl/pixel_to_pan_tilt_pulse.sv =====
`timescale 1ns / 1ps
// Turns a target pixel (pixel_x, pixel_y) into pan and tilt servo pulse widths in quarter
// microseconds. The block is a pipeline that takes one word per cycle and gives one result
// per word; a word passes through one input stage, sixteen CORDIC cells that work the
// pan and tilt angles and the two full-view angles side by side, a multiply stage, a sign
// stage, thirty-three restoring divider cells (one quotient bit each) and the output
// register. Any stall on the result side holds the whole row of cells. Calibration and
// range registers sit on the APB port at byte addresses 0, 4, ... 24 and may be written only
// while no word is in flight.
module pixel_to_pan_tilt_pulse
   import ptp_pkg::*;
#(
   parameter int FRAME_WIDTH  = 640,
   parameter int FRAME_HEIGHT = 480
) (
   input  logic        clock,
   input  logic        reset,
   ptp_req_if.sink     req_ch,
   ptp_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [12:0] FW = 13'(FRAME_WIDTH);
   localparam logic [12:0] FH = 13'(FRAME_HEIGHT);
   localparam logic [12:0] CX = 13'(FRAME_WIDTH / 2);
   localparam logic [12:0] CY = 13'(FRAME_HEIGHT / 2);

   typedef struct packed {
      logic                    valid;
      logic signed [34:0]      prod;
      logic                    adding;
      logic [ANG_W-1:0]        full;
   } mul_lane_type;

   logic [15:0] pan_min_ff, pan_max_ff, tilt_min_ff, tilt_max_ff;
   logic [15:0] cal_depth_ff, cal_width_ff, cal_height_ff;
   logic        csr_wr;
   logic        adv;
   logic        req_acc;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_min_ff    <= 16'd4000;
         pan_max_ff    <= 16'd8000;
         tilt_min_ff   <= 16'd4000;
         tilt_max_ff   <= 16'd8000;
         cal_depth_ff  <= 16'd1000;
         cal_width_ff  <= 16'd500;
         cal_height_ff <= 16'd375;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_PAN_MIN:    pan_min_ff    <= csr_pwdata[15:0];
            REG_PAN_MAX:    pan_max_ff    <= csr_pwdata[15:0];
            REG_TILT_MIN:   tilt_min_ff   <= csr_pwdata[15:0];
            REG_TILT_MAX:   tilt_max_ff   <= csr_pwdata[15:0];
            REG_CAL_DEPTH:  cal_depth_ff  <= csr_pwdata[15:0];
            REG_CAL_WIDTH:  cal_width_ff  <= csr_pwdata[15:0];
            REG_CAL_HEIGHT: cal_height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_PAN_MIN:    csr_prdata = {16'd0, pan_min_ff};
         REG_PAN_MAX:    csr_prdata = {16'd0, pan_max_ff};
         REG_TILT_MIN:   csr_prdata = {16'd0, tilt_min_ff};
         REG_TILT_MAX:   csr_prdata = {16'd0, tilt_max_ff};
         REG_CAL_DEPTH:  csr_prdata = {16'd0, cal_depth_ff};
         REG_CAL_WIDTH:  csr_prdata = {16'd0, cal_width_ff};
         REG_CAL_HEIGHT: csr_prdata = {16'd0, cal_height_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // pipeline control
   logic        rsp_valid_ff;
   logic [15:0] pan_pulse_ff, tilt_pulse_ff;

   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign req_acc = req_ch.valid && adv;

   // input stage
   cordic_word_type cw [0:CORDIC_STEPS];
   cordic_word_type cw0_in;
   logic [12:0] px, py, off_x, off_y;
   logic        low_x, low_y;

   always_comb begin
      px = {1'b0, req_ch.pixel_x};
      py = {1'b0, req_ch.pixel_y};
      low_x = px <= CX;
      low_y = py <= CY;
      off_x = low_x ? CX - px : px - CX;
      off_y = low_y ? CY - py : py - CY;
      cw0_in.valid = req_acc;
      cw0_in.low = {low_y, low_x};
      cw0_in.lane[0].y = $signed({3'd0, 29'(off_x) * 29'(cal_width_ff)});
      cw0_in.lane[0].x = $signed({3'd0, 29'(cal_depth_ff) * 29'(FW)});
      cw0_in.lane[1].y = $signed({16'd0, cal_width_ff});
      cw0_in.lane[1].x = $signed({16'd0, cal_depth_ff});
      cw0_in.lane[2].y = $signed({3'd0, 29'(off_y) * 29'(cal_height_ff)});
      cw0_in.lane[2].x = $signed({3'd0, 29'(cal_depth_ff) * 29'(FH)});
      cw0_in.lane[3].y = $signed({16'd0, cal_height_ff});
      cw0_in.lane[3].x = $signed({16'd0, cal_depth_ff});
      for (int k = 0; k < 4; k++) begin
         cw0_in.lane[k].z = 19'sd0;
         cw0_in.lane[k].zero = cw0_in.lane[k].y == 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw[0].valid <= 1'b0;
      end else if (adv) begin
         cw[0] <= cw0_in;
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      ptp_cordic_cell #(.STEP(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .word_in  (cw[g]),
         .word_out (cw[g+1])
      );
   end

   // multiply stage
   function automatic logic [ANG_W-1:0] clamp_ang(cordic_lane_type l);
      if (l.zero || l.z[18]) begin
         return '0;
      end
      return l.z[ANG_W-1:0];
   endfunction

   mul_lane_type mul_ff [2];
   mul_lane_type mul_in [2];
   logic signed [16:0] diff [2];

   always_comb begin
      diff[0] = $signed({1'b0, pan_max_ff}) - $signed({1'b0, pan_min_ff});
      diff[1] = $signed({1'b0, tilt_max_ff}) - $signed({1'b0, tilt_min_ff});
      for (int a = 0; a < 2; a++) begin
         mul_in[a].valid = cw[CORDIC_STEPS].valid;
         mul_in[a].prod = $signed({1'b0, clamp_ang(cw[CORDIC_STEPS].lane[2*a])}) * diff[a];
         mul_in[a].full = clamp_ang(cw[CORDIC_STEPS].lane[2*a+1]);
      end
      mul_in[0].adding = cw[CORDIC_STEPS].low[0];
      mul_in[1].adding = !cw[CORDIC_STEPS].low[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff[0].valid <= 1'b0;
         mul_ff[1].valid <= 1'b0;
      end else if (adv) begin
         mul_ff <= mul_in;
      end
   end

   // sign stage feeds the divider row
   div_word_type dw [0:MAG_W];
   div_word_type dw0_in;
   logic signed [34:0] sval [2];
   logic signed [34:0] smag [2];

   always_comb begin
      dw0_in.valid = mul_ff[0].valid;
      for (int a = 0; a < 2; a++) begin
         sval[a] = mul_ff[a].adding ? mul_ff[a].prod : -mul_ff[a].prod;
         smag[a] = sval[a][34] ? -sval[a] : sval[a];
         dw0_in.lane[a].rem = '0;
         dw0_in.lane[a].num = smag[a][MAG_W-1:0];
         dw0_in.lane[a].full = mul_ff[a].full;
         dw0_in.lane[a].neg = sval[a][34];
         dw0_in.lane[a].fz = mul_ff[a].full == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dw[0].valid <= 1'b0;
      end else if (adv) begin
         dw[0] <= dw0_in;
      end
   end

   for (genvar g = 0; g < MAG_W; g++) begin : g_div
      ptp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .word_in  (dw[g]),
         .word_out (dw[g+1])
      );
   end

   // midpoint, floor correction and saturation
   logic signed [35:0] quot [2];
   logic signed [35:0] res [2];
   logic [16:0]        mid [2];
   logic [15:0]        pulse [2];

   always_comb begin
      mid[0] = 17'({1'b0, pan_min_ff} + {1'b0, pan_max_ff}) >> 1;
      mid[1] = 17'({1'b0, tilt_min_ff} + {1'b0, tilt_max_ff}) >> 1;
      for (int a = 0; a < 2; a++) begin
         quot[a] = $signed({3'd0, dw[MAG_W].lane[a].num});
         if (dw[MAG_W].lane[a].neg) begin
            quot[a] = -(quot[a] + 36'(dw[MAG_W].lane[a].rem != '0));
         end
         res[a] = $signed({19'd0, mid[a]});
         if (!dw[MAG_W].lane[a].fz) begin
            res[a] = res[a] + quot[a];
         end
         if (res[a][35]) begin
            pulse[a] = 16'd0;
         end else if (res[a] > 36'sd65535) begin
            pulse[a] = 16'hFFFF;
         end else begin
            pulse[a] = res[a][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff  <= dw[MAG_W].valid;
         pan_pulse_ff  <= pulse[0];
         tilt_pulse_ff <= pulse[1];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pan_pulse = pan_pulse_ff;
   assign rsp_ch.tilt_pulse = tilt_pulse_ff;

`ifndef NO_ASSERTIONS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> cw[0].valid)
      else $error("accepted word did not enter the cordic row");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dw[MAG_W]) && $stable(cw[CORDIC_STEPS]))
      else $error("cells moved during a stall");

   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      dw[MAG_W].valid && adv |=> rsp_valid_ff)
      else $error("divider result lost on the way out");
`endif

endmodule
